// ----- hw/rtl/pms_pkg.sv -----
// pms_pkg: shared widths, register indexes, reset values and payload types
// for the period to mix step converter
// no dependencies
package pms_pkg;

  // field widths
  localparam int PERIOD_W  = 16;
  localparam int LIM_W     = 15;
  localparam int RATE_W    = 16;
  localparam int HZ_W      = 24;
  localparam int STEP_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // reference clock divided by the period gives the note frequency
  localparam logic [HZ_W-1:0] FREQ_CLOCK = HZ_W'(14317056);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PER_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PER_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_RATE = 2'd3;

  // configuration reset values
  localparam logic [LIM_W-1:0]  RST_PER_MIN  = LIM_W'(64);
  localparam logic [LIM_W-1:0]  RST_PER_MAX  = LIM_W'(32767);
  localparam logic [RATE_W-1:0] RST_MIX_RATE = RATE_W'(43478);

  // configuration as seen by the datapath
  typedef struct packed {
    logic              limits;
    logic [LIM_W-1:0]  period_min;
    logic [LIM_W-1:0]  period_max;
    logic [RATE_W-1:0] mix_rate;
  } cfg_t;

  // values carried alongside the frequency division
  typedef struct packed {
    logic [PERIOD_W-1:0] cur_out;
    logic [PERIOD_W-1:0] orig_out;
    logic                silent;
  } side1_t;

  // values carried alongside the step division
  typedef struct packed {
    side1_t          s1;
    logic [HZ_W-1:0] hz;
  } side2_t;

endpackage

// ----- hw/rtl/pms_if.sv -----
// pms_in_if / pms_out_if: valid-ready channels of the period to mix step converter
// depends on pms_pkg for field widths
interface pms_in_if;
  logic                          valid;
  logic                          ready;
  logic [pms_pkg::PERIOD_W-1:0]  cur_period;
  logic [pms_pkg::PERIOD_W-1:0]  orig_period;

  modport source (output valid, output cur_period, output orig_period, input ready);
  modport sink   (input valid, input cur_period, input orig_period, output ready);
endinterface

interface pms_out_if;
  logic                          valid;
  logic                          ready;
  logic [pms_pkg::PERIOD_W-1:0]  cur_period_out;
  logic [pms_pkg::PERIOD_W-1:0]  orig_period_out;
  logic [pms_pkg::STEP_W-1:0]    mix_step;
  logic [pms_pkg::HZ_W-1:0]      freq_value;
  logic                          silent;

  modport source (output valid, output cur_period_out, output orig_period_out,
                  output mix_step, output freq_value, output silent, input ready);
  modport sink   (input valid, input cur_period_out, input orig_period_out,
                  input mix_step, input freq_value, input silent, output ready);
endinterface

// ----- hw/rtl/period_to_mix_step.sv -----
// period_to_mix_step: note period to frequency and 16.16 mixing step
// stages in order are the clamp stage, the frequency divider, the step divider and the output register
// throughput one word per cycle while the output is not stalled, set by the clamp stage and two pipelined dividers
// while a full output register is stalled, earlier stages keep taking words until the pipeline fills
// synchronous reset clears all valid bits and loads register defaults
module period_to_mix_step #(
  parameter int DIV1_BITS = 3,
  parameter int DIV2_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pms_pkg::CFG_W-1:0]       cfg_data,
  pms_in_if.sink                          period,
  pms_out_if.source                       step
);
  import pms_pkg::*;

  localparam int DIV2_DW = HZ_W + FRAC_W;

  cfg_t cfg;

  logic             c_valid;
  logic             c_ready;
  side1_t           c_side;
  logic [LIM_W-1:0] c_divisor;

  logic                d1_valid;
  logic                d1_ready;
  logic [HZ_W-1:0]     d1_quot;
  logic [$bits(side1_t)-1:0] d1_side_raw;
  side1_t              d1_side;
  side2_t              d2_side_in;

  logic                 d2_valid;
  logic                 d2_ready;
  logic [DIV2_DW-1:0]   d2_quot;
  logic [$bits(side2_t)-1:0] d2_side_raw;
  side2_t               d2_side;

  logic out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limits     <= 1'b0;
      cfg.period_min <= RST_PER_MIN;
      cfg.period_max <= RST_PER_MAX;
      cfg.mix_rate   <= RST_MIX_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIMITS:   cfg.limits     <= cfg_data[0];
        REG_PER_MIN:  cfg.period_min <= cfg_data[LIM_W-1:0];
        REG_PER_MAX:  cfg.period_max <= cfg_data[LIM_W-1:0];
        REG_MIX_RATE: cfg.mix_rate   <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp stage
  pms_clamp u_clamp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .period      (period),
    .out_valid   (c_valid),
    .out_ready   (c_ready),
    .out_side    (c_side),
    .out_divisor (c_divisor)
  );

  // frequency = clock / period
  pms_div #(
    .DW  (HZ_W),
    .RW  (LIM_W),
    .BPS (DIV1_BITS),
    .SW  ($bits(side1_t))
  ) u_div_freq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (c_valid),
    .in_ready    (c_ready),
    .in_dividend (FREQ_CLOCK),
    .in_divisor  (c_divisor),
    .in_side     (c_side),
    .out_valid   (d1_valid),
    .out_ready   (d1_ready),
    .out_quot    (d1_quot),
    .out_side    (d1_side_raw)
  );

  assign d1_side       = side1_t'(d1_side_raw);
  assign d2_side_in.s1 = d1_side;
  assign d2_side_in.hz = d1_quot;

  // step = frequency * 65536 / mix rate, a zero rate gives all ones
  pms_div #(
    .DW  (DIV2_DW),
    .RW  (RATE_W),
    .BPS (DIV2_BITS),
    .SW  ($bits(side2_t))
  ) u_div_step (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (d1_valid),
    .in_ready    (d1_ready),
    .in_dividend ({d1_quot, FRAC_W'(0)}),
    .in_divisor  (cfg.mix_rate),
    .in_side     (d2_side_in),
    .out_valid   (d2_valid),
    .out_ready   (d2_ready),
    .out_quot    (d2_quot),
    .out_side    (d2_side_raw)
  );

  assign d2_side = side2_t'(d2_side_raw);

  // output register, silence forces frequency and step to zero
  assign d2_ready = !out_valid || step.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d2_ready) begin
      out_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d2_ready && d2_valid) begin
      step.cur_period_out  <= d2_side.s1.cur_out;
      step.orig_period_out <= d2_side.s1.orig_out;
      step.silent          <= d2_side.s1.silent;
      step.freq_value      <= d2_side.s1.silent ? '0 : d2_side.hz;
      step.mix_step        <= d2_side.s1.silent ? '0 : d2_quot[STEP_W-1:0];
    end
  end

  assign step.valid = out_valid;

endmodule

// ----- hw/rtl/pms_clamp.sv -----
// pms_clamp: first pipeline stage, clamps the periods and picks the divisor
// depends on pms_pkg and pms_in_if
module pms_clamp (
  input  logic                        clk,
  input  logic                        rst,
  input  pms_pkg::cfg_t               cfg,
  pms_in_if.sink                      period,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pms_pkg::side1_t             out_side,
  output logic [pms_pkg::LIM_W-1:0]   out_divisor
);
  import pms_pkg::*;

  logic [PERIOD_W-1:0] max_ext;
  logic [PERIOD_W-1:0] min_ext;
  logic [PERIOD_W-1:0] orig_c;
  logic [PERIOD_W-1:0] cur_c;
  logic [PERIOD_W-1:0] eff;
  logic                silent_c;
  logic                valid;
  logic                rdy;

  assign max_ext = PERIOD_W'(cfg.period_max);
  assign min_ext = PERIOD_W'(cfg.period_min);

  // clamp original period when limits are on, cap the effective period, then raise it unless zero
  always_comb begin
    orig_c = period.orig_period;
    if (cfg.limits) begin
      if (orig_c > max_ext) orig_c = max_ext;
      if (orig_c < min_ext) orig_c = min_ext;
    end
    eff   = period.cur_period;
    cur_c = period.cur_period;
    if (eff > max_ext) begin
      eff = max_ext;
      if (cfg.limits) cur_c = eff;
    end
    silent_c = (eff == '0);
    if (!silent_c && (eff < min_ext)) begin
      eff = min_ext;
      if (cfg.limits) cur_c = eff;
    end
  end

  // stage moves when empty or when the next stage takes its word
  assign rdy          = !valid || out_ready;
  assign period.ready = rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rdy) begin
      valid <= period.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && period.valid) begin
      out_side.cur_out  <= cur_c;
      out_side.orig_out <= orig_c;
      out_side.silent   <= silent_c;
      out_divisor       <= eff[LIM_W-1:0];
    end
  end

  assign out_valid = valid;

endmodule

// ----- hw/rtl/pms_div.sv -----
// pms_div: pipelined restoring divider, up to BPS quotient bits per stage,
// with a sideband that travels with each word; depends on pms_pkg
module pms_div #(
  parameter int DW  = 24,
  parameter int RW  = 15,
  parameter int BPS = 3,
  parameter int SW  = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_dividend,
  input  logic [RW-1:0] in_divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_quot,
  output logic [SW-1:0] out_side
);
  import pms_pkg::*;

  localparam int NST = (DW + BPS - 1) / BPS;

  logic [NST-1:0]         v;
  logic [NST:0]           mv;
  logic [NST-1:0][RW-1:0] rem;
  logic [NST-1:0][DW-1:0] dq;
  logic [NST-1:0][RW-1:0] dv;
  logic [NST-1:0][SW-1:0] sd;

  // a stage moves when empty or when the stage after it moves
  assign mv[NST] = out_ready;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic          src_v;
    logic [RW-1:0] src_rem;
    logic [DW-1:0] src_dq;
    logic [RW-1:0] src_dv;
    logic [SW-1:0] src_sd;
    logic [RW-1:0] r;
    logic [DW-1:0] q;
    logic [RW:0]   t;

    assign mv[s] = !v[s] || mv[s+1];

    if (s == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_rem = '0;
      assign src_dq  = in_dividend;
      assign src_dv  = in_divisor;
      assign src_sd  = in_side;
    end else begin : g_next
      assign src_v   = v[s-1];
      assign src_rem = rem[s-1];
      assign src_dq  = dq[s-1];
      assign src_dv  = dv[s-1];
      assign src_sd  = sd[s-1];
    end

    // shift in one dividend bit, subtract when it fits, per quotient bit
    always_comb begin
      r = src_rem;
      q = src_dq;
      t = '0;
      for (int k = 0; k < BPS; k++) begin
        if (s * BPS + k < DW) begin
          t = {r, q[DW-1]};
          if (t >= {1'b0, src_dv}) begin
            t = t - {1'b0, src_dv};
            r = t[RW-1:0];
            q = {q[DW-2:0], 1'b1};
          end else begin
            r = t[RW-1:0];
            q = {q[DW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (mv[s]) begin
        v[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (mv[s] && src_v) begin
        rem[s] <= r;
        dq[s]  <= q;
        dv[s]  <= src_dv;
        sd[s]  <= src_sd;
      end
    end
  end

  assign in_ready  = mv[0];
  assign out_valid = v[NST-1];
  assign out_quot  = dq[NST-1];
  assign out_side  = sd[NST-1];

endmodule
